// ===== hw/rtl/smp_pkg.sv =====
`timescale 1ns / 1ps

package smp_pkg;

  localparam int MaxJoints = 64;
  localparam int JointW    = $clog2(MaxJoints);
  localparam int FracBits  = 16;
  // Exact sum of four 64-bit products.
  localparam int AccW      = 66;

  localparam logic signed [31:0] FixOne   = 32'sd1 <<< FracBits;
  localparam logic signed [31:0] InvTwoPi = 32'sd683565276;
  localparam logic signed [31:0] Q30One   = 32'sd1073741824;
  localparam logic signed [31:0] SinSeed  = 32'sd172272;
  localparam logic signed [31:0] SinCoef [4] = '{
    -32'sd5026995, 32'sd85569306, -32'sd693598668, 32'sd1686629713
  };

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_POSE = 1'b1;

  // One 4x4 product pass of the matrix engine.
  typedef enum logic [2:0] {
    P_RX, P_RY, P_RZ, P_TR, P_PAR, P_BIND
  } pass_e;

  // Round half up to FracBits and saturate to 32 bits.
  function automatic logic signed [31:0] round_sat(input logic signed [AccW-1:0] s);
    logic signed [AccW-1:0] half;
    logic signed [AccW-1:0] t;
    half = AccW'(1) << (FracBits - 1);
    t    = (s + half) >>> FracBits;
    if (t > 66'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (t < -66'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return t[31:0];
    end
  endfunction

endpackage

// ===== hw/rtl/skinning_matrix_palette_core.sv =====
`timescale 1ns / 1ps

// Skinning matrix palette. A load item (opcode 0) writes one row of a joint's
// inverse bind-pose matrix and gives no result. A pose item (opcode 1) builds
// local = S*Rx*Ry*Rz*T, global = local*global[parent] (local alone for joint
// 0), stores global and returns invBind*global as four row items, row 0
// first, last_row set on row 3. Values are Q16.16; every 4x4 product rounds
// half up and saturates. Sine and cosine come from a phase multiply and an
// odd Horner polynomial. All arithmetic shares one registered 32x32
// multiplier, used in turn by the three angles, the local and parent product
// passes and, after the global write-back, the bind product pass. A pose
// holds the input until the core is idle again (joint 0 skips the parent
// product); a load does not hold it. Globals live in a 1024x32 memory; a
// joint never posed reads as identity through a per-joint valid bit. Bind
// rows live in a 256x128 memory.
// Results sit in an output buffer, so the next item is accepted while the
// previous rows drain; a pose only waits at its end if that buffer is full.
module skinning_matrix_palette_core
  import smp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                opcode_i,
  input  logic [5:0]          joint_index_i,
  input  logic [5:0]          aux_index_i,
  input  logic signed [31:0]  w0_i,
  input  logic signed [31:0]  w1_i,
  input  logic signed [31:0]  w2_i,
  input  logic signed [31:0]  w3_i,
  input  logic signed [31:0]  w4_i,
  input  logic signed [31:0]  w5_i,
  input  logic signed [31:0]  w6_i,
  input  logic signed [31:0]  w7_i,
  input  logic signed [31:0]  w8_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [5:0]          out_joint_o,
  output logic [1:0]          out_row_o,
  output logic signed [31:0]  m0_o,
  output logic signed [31:0]  m1_o,
  output logic signed [31:0]  m2_o,
  output logic signed [31:0]  m3_o,
  output logic                last_row_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_ANG_MUL, S_ANG_PH, S_X_SET, S_X2_MUL, S_X2_GET,
    S_H_MUL, S_H_ADD, S_F_MUL, S_F_GET, S_MM, S_MM_END, S_WB
  } state_e;

  localparam int GAddrW = JointW + 4;
  localparam int BAddrW = JointW + 2;

  state_e state_q;
  pass_e  pass_q;

  // memories
  logic [31:0]  gmem [MaxJoints*16];
  logic [127:0] bmem [MaxJoints*4];
  logic [31:0]  gmem_rd_q;
  logic [127:0] bmem_rd_q;
  logic [GAddrW-1:0] g_raddr, g_waddr;
  logic [BAddrW-1:0] b_raddr, b_waddr;
  logic        g_we, b_we;
  logic [127:0] b_wdata;

  logic [MaxJoints-1:0] vld_q;

  // item registers
  logic [JointW-1:0]   joint_q, parent_q;
  logic                root_q;
  logic signed [31:0]  tr_q [3];
  logic signed [31:0]  ang_q [3];
  logic signed [31:0]  sn_q [3];
  logic signed [31:0]  cs_q [3];

  // trig sequencer
  logic [1:0]          a_q, hc_q;
  logic                cos_sel_q;
  logic [31:0]         ph_q;
  logic [1:0]          quad_q;
  logic signed [31:0]  x_q, x2_q, p_q;

  // matrix engine
  logic signed [31:0]  lmat_q [16];
  logic signed [31:0]  rmat_q [16];
  logic [5:0]          cnt_q, idx1_q, idx2_q;
  logic                iss_done_q, v1_q, v2_q;
  logic signed [AccW-1:0] acc_q;
  logic [3:0]          wb_q;

  // shared multiplier
  logic signed [31:0]  mul_a, mul_b;
  logic signed [63:0]  prod_q;

  // output buffer
  logic                out_busy_q;
  logic [1:0]          out_row_q;
  logic [5:0]          out_joint_q;
  logic signed [31:0]  obuf_q [16];

  logic in_acc, out_acc;
  logic load_ok, pose_ok;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_o && out_ready_i;

  assign load_ok = (32'(joint_index_i) < MaxJoints) && (aux_index_i < 6'd4);
  assign pose_ok = (32'(joint_index_i) < MaxJoints) &&
                   ((joint_index_i == 6'd0) || (32'(aux_index_i) < MaxJoints));

  // ---------------------------------------------------------------- engine
  logic [1:0] i1, j1, k1, i2, j2, k2;
  assign {i1, j1, k1} = idx1_q;
  assign {i2, j2, k2} = idx2_q;

  logic signed [31:0] bsel, lrd, gen, ident, eng_a, eng_b;
  logic [3:0]         laddr;

  assign bsel  = bmem_rd_q[32*k1 +: 32];
  assign laddr = (pass_q == P_BIND) ? {k1, j1} : {i1, k1};
  assign lrd   = lmat_q[laddr];
  assign ident = (k1 == j1) ? FixOne : 32'sd0;

  // Right-hand operand of the current pass, entry (k, j).
  always_comb begin
    gen = ident;
    unique case (pass_q)
      P_RX: begin
        if (k1 == 2'd1 && j1 == 2'd1) gen = cs_q[0];
        if (k1 == 2'd1 && j1 == 2'd2) gen = sn_q[0];
        if (k1 == 2'd2 && j1 == 2'd1) gen = -sn_q[0];
        if (k1 == 2'd2 && j1 == 2'd2) gen = cs_q[0];
      end
      P_RY: begin
        if (k1 == 2'd0 && j1 == 2'd0) gen = cs_q[1];
        if (k1 == 2'd0 && j1 == 2'd2) gen = -sn_q[1];
        if (k1 == 2'd2 && j1 == 2'd0) gen = sn_q[1];
        if (k1 == 2'd2 && j1 == 2'd2) gen = cs_q[1];
      end
      P_RZ: begin
        if (k1 == 2'd0 && j1 == 2'd0) gen = cs_q[2];
        if (k1 == 2'd0 && j1 == 2'd1) gen = sn_q[2];
        if (k1 == 2'd1 && j1 == 2'd0) gen = -sn_q[2];
        if (k1 == 2'd1 && j1 == 2'd1) gen = cs_q[2];
      end
      P_TR: begin
        if (k1 == 2'd3 && j1 != 2'd3) gen = tr_q[j1];
      end
      P_PAR:   gen = vld_q[parent_q] ? gmem_rd_q : ident;
      P_BIND:  gen = lrd;
      default: gen = ident;
    endcase
  end

  assign eng_a = (pass_q == P_BIND) ? bsel : lrd;
  assign eng_b = gen;

  // ---------------------------------------------------------------- trig
  logic [31:0]        phase;
  logic [29:0]        frac;
  logic signed [31:0] xnew, tq, tc, rq, trig_res;

  assign phase = ph_q + (cos_sel_q ? 32'h4000_0000 : 32'h0);
  assign frac  = phase[29:0];
  assign xnew  = phase[30] ? (Q30One - $signed({2'b00, frac})) : $signed({2'b00, frac});
  assign tq    = prod_q[61:30];
  assign tc    = (tq < 32'sd0) ? 32'sd0 : ((tq > Q30One) ? Q30One : tq);
  assign rq    = (tc + (32'sd1 <<< (29 - FracBits))) >>> (30 - FracBits);
  assign trig_res = quad_q[1] ? -rq : rq;

  always_comb begin
    mul_a = eng_a;
    mul_b = eng_b;
    priority case (state_q)
      S_ANG_MUL: begin mul_a = ang_q[a_q]; mul_b = InvTwoPi; end
      S_X2_MUL:  begin mul_a = x_q;        mul_b = x_q;      end
      S_H_MUL:   begin mul_a = p_q;        mul_b = x2_q;     end
      S_F_MUL:   begin mul_a = p_q;        mul_b = x_q;      end
      default: begin
        mul_a = eng_a;
        mul_b = eng_b;
      end
    endcase
  end

  // ---------------------------------------------------------------- memories
  assign g_raddr = {parent_q, cnt_q[1:0], cnt_q[3:2]};
  assign g_waddr = {joint_q, wb_q};
  assign g_we    = (state_q == S_WB);
  assign b_raddr = {joint_q, cnt_q[5:4]};
  assign b_waddr = {JointW'(joint_index_i), aux_index_i[1:0]};
  assign b_we    = in_acc && (opcode_i == OP_LOAD) && load_ok;
  assign b_wdata = {w3_i, w2_i, w1_i, w0_i};

  always_ff @(posedge clk_i) begin
    if (g_we) begin
      gmem[g_waddr] <= rmat_q[wb_q];
    end
    gmem_rd_q <= gmem[g_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      bmem[b_waddr] <= b_wdata;
    end
    bmem_rd_q <= bmem[b_raddr];
  end

  // ---------------------------------------------------------------- datapath
  logic signed [AccW-1:0] prod_x, sum;
  assign prod_x = AccW'(prod_q);
  assign sum    = (k2 == 2'd0) ? prod_x : (acc_q + prod_x);

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    idx1_q <= cnt_q;
    idx2_q <= idx1_q;
    if (v2_q) begin
      acc_q <= sum;
      if (k2 == 2'd3) rmat_q[{i2, j2}] <= round_sat(sum);
    end
    if (in_acc && opcode_i == OP_POSE) begin
      joint_q  <= JointW'(joint_index_i);
      parent_q <= JointW'(aux_index_i);
      root_q   <= (joint_index_i == 6'd0);
      tr_q[0]  <= w0_i; tr_q[1] <= w1_i; tr_q[2] <= w2_i;
      ang_q[0] <= w3_i; ang_q[1] <= w4_i; ang_q[2] <= w5_i;
      // scale matrix on the diagonal, zero elsewhere
      for (int e = 0; e < 16; e++) begin
        if (e == 0)       lmat_q[e] <= w6_i;
        else if (e == 5)  lmat_q[e] <= w7_i;
        else if (e == 10) lmat_q[e] <= w8_i;
        else if (e == 15) lmat_q[e] <= FixOne;
        else              lmat_q[e] <= 32'sd0;
      end
    end
    if (state_q == S_MM_END && pass_q != P_BIND) begin
      for (int e = 0; e < 16; e++) lmat_q[e] <= rmat_q[e];
    end
    if (state_q == S_ANG_PH) ph_q <= prod_q[FracBits +: 32];
    if (state_q == S_X_SET) begin
      quad_q <= phase[31:30];
      x_q    <= xnew;
    end
    if (state_q == S_X2_GET) begin
      x2_q <= prod_q[61:30];
      p_q  <= SinSeed;
    end
    if (state_q == S_H_ADD) p_q <= SinCoef[hc_q] + prod_q[61:30];
    if (state_q == S_F_GET) begin
      if (cos_sel_q) cs_q[a_q] <= trig_res;
      else           sn_q[a_q] <= trig_res;
    end
    if (state_q == S_MM_END && pass_q == P_BIND && !out_busy_q) begin
      for (int e = 0; e < 16; e++) obuf_q[e] <= rmat_q[e];
      out_joint_q <= 6'(joint_q);
    end
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pass_q     <= P_RX;
      a_q        <= 2'd0;
      hc_q       <= 2'd0;
      cos_sel_q  <= 1'b0;
      cnt_q      <= 6'd0;
      iss_done_q <= 1'b1;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      wb_q       <= 4'd0;
      vld_q      <= '0;
      out_busy_q <= 1'b0;
      out_row_q  <= 2'd0;
    end else begin
      v1_q <= (state_q == S_MM) && !iss_done_q;
      v2_q <= v1_q;
      if (out_acc) begin
        out_row_q <= out_row_q + 2'd1;
        if (out_row_q == 2'd3) out_busy_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && opcode_i == OP_POSE && pose_ok) begin
            a_q     <= 2'd0;
            state_q <= S_ANG_MUL;
          end
        end
        S_ANG_MUL: state_q <= S_ANG_PH;
        S_ANG_PH: begin
          cos_sel_q <= 1'b0;
          state_q   <= S_X_SET;
        end
        S_X_SET:  state_q <= S_X2_MUL;
        S_X2_MUL: state_q <= S_X2_GET;
        S_X2_GET: begin
          hc_q    <= 2'd0;
          state_q <= S_H_MUL;
        end
        S_H_MUL: state_q <= S_H_ADD;
        S_H_ADD: begin
          hc_q    <= hc_q + 2'd1;
          state_q <= (hc_q == 2'd3) ? S_F_MUL : S_H_MUL;
        end
        S_F_MUL: state_q <= S_F_GET;
        S_F_GET: begin
          if (!cos_sel_q) begin
            cos_sel_q <= 1'b1;
            state_q   <= S_X_SET;
          end else if (a_q == 2'd2) begin
            pass_q     <= P_RX;
            cnt_q      <= 6'd0;
            iss_done_q <= 1'b0;
            state_q    <= S_MM;
          end else begin
            a_q     <= a_q + 2'd1;
            state_q <= S_ANG_MUL;
          end
        end
        S_MM: begin
          if (!iss_done_q) begin
            cnt_q <= cnt_q + 6'd1;
            if (cnt_q == 6'd63) iss_done_q <= 1'b1;
          end
          if (v2_q && idx2_q == 6'd63) state_q <= S_MM_END;
        end
        S_MM_END: begin
          priority if (pass_q == P_BIND) begin
            if (!out_busy_q) begin
              out_busy_q <= 1'b1;
              out_row_q  <= 2'd0;
              state_q    <= S_IDLE;
            end
          end else if (pass_q == P_PAR || (pass_q == P_TR && root_q)) begin
            wb_q    <= 4'd0;
            state_q <= S_WB;
          end else begin
            pass_q     <= pass_e'(pass_q + 3'd1);
            cnt_q      <= 6'd0;
            iss_done_q <= 1'b0;
            state_q    <= S_MM;
          end
        end
        S_WB: begin
          wb_q <= wb_q + 4'd1;
          if (wb_q == 4'd15) begin
            vld_q[joint_q] <= 1'b1;
            pass_q         <= P_BIND;
            cnt_q          <= 6'd0;
            iss_done_q     <= 1'b0;
            state_q        <= S_MM;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- outputs
  assign out_valid_o = out_busy_q;
  assign out_joint_o = out_joint_q;
  assign out_row_o   = out_row_q;
  assign m0_o        = obuf_q[{out_row_q, 2'd0}];
  assign m1_o        = obuf_q[{out_row_q, 2'd1}];
  assign m2_o        = obuf_q[{out_row_q, 2'd2}];
  assign m3_o        = obuf_q[{out_row_q, 2'd3}];
  assign last_row_o  = (out_row_q == 2'd3);

  // ---------------------------------------------------------------- checks
  a_mul_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (state_q == S_MM))
    else $error("engine pipe active outside a matrix pass");

  a_pass_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MM_END) |-> (!v1_q && !v2_q))
    else $error("pass ended with products in flight");

  a_wb_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB) |-> (pass_q == P_TR || pass_q == P_PAR))
    else $error("global write-back after wrong pass");

  a_out_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_row_q == 2'd3) |=> !out_busy_q)
    else $error("output buffer not released after row 3");

endmodule
